// ----- sv/pda_pkg.sv -----
// Shared constants and types for the pushdown automaton recognizer.
`timescale 1ns / 1ps

package pda_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int NUM_STATES  = 16;
	localparam int STACK_DEPTH = 64;
	localparam int MAX_PUSH    = 4;

	localparam int ENTRY_W = $clog2(NUM_ENTRIES);
	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int SYM_W   = 8;
	localparam int PUSH_W  = SYM_W * MAX_PUSH;
	localparam int PLEN_W  = 3;
	localparam int PSEL_W  = $clog2(MAX_PUSH);
	localparam int SADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int CODE_W  = 3;
	localparam int KIND_W  = 2;

	localparam logic [SYM_W-1:0] SYM_BOTTOM = 8'h5A;
	localparam logic [SYM_W-1:0] SYM_EMPTY  = 8'h7E;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

	localparam logic [CODE_W-1:0] V_ACCEPT    = 3'd0;
	localparam logic [CODE_W-1:0] V_NOMATCH   = 3'd1;
	localparam logic [CODE_W-1:0] V_UNDER     = 3'd2;
	localparam logic [CODE_W-1:0] V_NOTBOTTOM = 3'd3;
	localparam logic [CODE_W-1:0] V_OVER      = 3'd4;

	typedef struct packed {
		logic [STATE_W-1:0] from_state;
		logic [STATE_W-1:0] to_state;
		logic [SYM_W-1:0]   symbol;
		logic [SYM_W-1:0]   top_sym;
		logic [PUSH_W-1:0]  push_syms;
		logic [PLEN_W-1:0]  push_len;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef struct packed {
		logic capture;
		logic tbl_write;
		logic tbl_clear;
		logic mark_started;
		logic reject_under;
		logic scan_start;
		logic scan_step;
		logic reject_nomatch;
		logic take_hit;
		logic push_skip;
		logic push_write;
		logic reject_over;
		logic finish_symbol;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic rejected;
		logic stack_empty;
		logic hit;
		logic scan_last;
		logic push_done;
		logic push_empty_sym;
		logic stack_full;
		logic out_free;
	} status_t;

endpackage

// ----- sv/pda_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/pda_ctrl.sv -----
// Controller state machine: sequences load, clear, symbol scan/push and end beats.
`timescale 1ns / 1ps

module pda_ctrl import pda_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_stall,
	output cmd_t              cmd,
	input  status_t           status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_CLEAR,
		S_SYM,
		S_SCAN,
		S_PUSH,
		S_END
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (kind)
						KIND_LOAD:   state_d = S_LOAD;
						KIND_CLEAR:  state_d = S_CLEAR;
						KIND_SYMBOL: state_d = S_SYM;
						default:     state_d = S_END;
					endcase
				end
			end
			S_LOAD: begin
				cmd.tbl_write = 1'b1;
				state_d       = S_IDLE;
			end
			S_CLEAR: begin
				cmd.tbl_clear = 1'b1;
				state_d       = S_IDLE;
			end
			S_SYM: begin
				cmd.mark_started = 1'b1;
				if (status.rejected) begin
					state_d = S_IDLE;
				end else if (status.stack_empty) begin
					cmd.reject_under = 1'b1;
					state_d          = S_IDLE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = S_PUSH;
				end else if (status.scan_last) begin
					cmd.reject_nomatch = 1'b1;
					state_d            = S_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_PUSH: begin
				if (status.push_done) begin
					cmd.finish_symbol = 1'b1;
					state_d           = S_IDLE;
				end else if (status.push_empty_sym) begin
					cmd.push_skip = 1'b1;
				end else if (status.stack_full) begin
					// overflow: keep the current state, stop pushing
					cmd.reject_over = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.push_write = 1'b1;
				end
			end
			S_END: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule

// ----- sv/pda_dpath.sv -----
// Datapath: transition table, stack, automaton state and verdict output register.
`timescale 1ns / 1ps

module pda_dpath import pda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [ENTRY_W-1:0] entry_index,
	input  logic [STATE_W-1:0] from_state,
	input  logic [STATE_W-1:0] to_state,
	input  logic [SYM_W-1:0]   symbol,
	input  logic [SYM_W-1:0]   stack_top_match,
	input  logic [PUSH_W-1:0]  push_symbols,
	input  logic [PLEN_W-1:0]  push_length,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STATE_W-1:0] cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [CODE_W-1:0]  verdict_code
);

	// captured input beat
	logic [ENTRY_W-1:0] idx_q;
	entry_t             item_q;
	logic [SYM_W-1:0]   sym_q;

	// automaton state
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       count_q;
	logic [SYM_W-1:0]       bottom_q;
	logic [STATE_W-1:0]     cur_state_q;
	logic [STATE_W-1:0]     init_q;
	logic [CODE_W-1:0]      reject_q;
	logic                   started_q;

	// scan and push
	logic [ENTRY_W-1:0] scan_idx_q;
	logic               rd_bottom_q;
	logic [STATE_W-1:0] hit_to_q;
	logic [PUSH_W-1:0]  hit_push_q;
	logic [PLEN_W-1:0]  push_k_q;

	// output register
	logic              out_valid_q;
	logic              accepted_q;
	logic [CODE_W-1:0] verdict_q;

	logic [ENTRY_BITS-1:0] tbl_rdata;
	entry_t                rd_entry;
	logic [ENTRY_W-1:0]    tbl_raddr;
	logic                  tbl_re;
	logic [SYM_W-1:0]      stk_rdata;
	logic [CNT_W-1:0]      count_m1;
	logic [SYM_W-1:0]      top_sym;
	logic [SYM_W-1:0]      push_bytes [MAX_PUSH];
	logic [PSEL_W-1:0]     push_sel;
	logic [SYM_W-1:0]      push_sym;
	logic [CODE_W-1:0]     verdict;
	logic                  cfg_fire;

	assign tbl_re    = cmd.scan_start | cmd.scan_step;
	assign tbl_raddr = cmd.scan_start ? '0 : ENTRY_W'(scan_idx_q + 1'b1);

	pda_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(NUM_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (cmd.tbl_write),
		.waddr(idx_q),
		.wdata(item_q),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	assign count_m1 = count_q - 1'b1;

	pda_ram #(
		.WIDTH(SYM_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push_write),
		.waddr(count_q[SADDR_W-1:0]),
		.wdata(push_sym),
		.re   (cmd.scan_start),
		.raddr(count_m1[SADDR_W-1:0]),
		.rdata(stk_rdata)
	);

	assign rd_entry = entry_t'(tbl_rdata);
	// slot zero lives in a register so it reads as the bottom symbol after reset
	assign top_sym  = rd_bottom_q ? bottom_q : stk_rdata;

	always_comb begin
		for (int i = 0; i < MAX_PUSH; i++) begin
			push_bytes[i] = hit_push_q[i*SYM_W +: SYM_W];
		end
	end

	// push string goes on last character first
	assign push_sel = PSEL_W'(push_k_q - 1'b1);
	assign push_sym = push_bytes[push_sel];

	always_comb begin
		if (reject_q != V_ACCEPT) begin
			verdict = reject_q;
		end else if (count_q == CNT_W'(1) && bottom_q == SYM_BOTTOM) begin
			verdict = V_ACCEPT;
		end else begin
			verdict = V_NOTBOTTOM;
		end
	end

	assign status.rejected       = (reject_q != V_ACCEPT);
	assign status.stack_empty    = (count_q == '0);
	assign status.hit            = valid_q[scan_idx_q]
	                               && rd_entry.from_state == cur_state_q
	                               && rd_entry.symbol == sym_q
	                               && rd_entry.top_sym == top_sym;
	assign status.scan_last      = (scan_idx_q == ENTRY_W'(NUM_ENTRIES - 1));
	assign status.push_done      = (push_k_q == '0);
	assign status.push_empty_sym = (push_sym == SYM_EMPTY);
	assign status.stack_full     = (count_q >= CNT_W'(STACK_DEPTH));
	assign status.out_free       = !out_valid_q || !out_stall;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// capture the beat; clamp the push length
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q            <= entry_index;
			sym_q            <= symbol;
			item_q.from_state <= from_state;
			item_q.to_state  <= to_state;
			item_q.symbol    <= symbol;
			item_q.top_sym   <= stack_top_match;
			item_q.push_syms <= push_symbols;
			item_q.push_len  <= (push_length > PLEN_W'(MAX_PUSH)) ?
			                    PLEN_W'(MAX_PUSH) : push_length;
		end
		if (cmd.take_hit) begin
			hit_to_q   <= rd_entry.to_state;
			hit_push_q <= rd_entry.push_syms;
		end
		if (cmd.emit) begin
			accepted_q <= (verdict == V_ACCEPT);
			verdict_q  <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= CNT_W'(1);
			bottom_q    <= SYM_BOTTOM;
			cur_state_q <= '0;
			init_q      <= '0;
			reject_q    <= V_ACCEPT;
			started_q   <= 1'b0;
			scan_idx_q  <= '0;
			rd_bottom_q <= 1'b0;
			push_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tbl_write) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.tbl_clear) begin
				valid_q <= '0;
			end
			if (cmd.mark_started) begin
				started_q <= 1'b1;
			end
			if (cmd.reject_under) begin
				reject_q <= V_UNDER;
			end
			if (cmd.scan_start) begin
				scan_idx_q  <= '0;
				rd_bottom_q <= (count_q == CNT_W'(1));
			end
			if (cmd.scan_step) begin
				scan_idx_q <= ENTRY_W'(scan_idx_q + 1'b1);
			end
			if (cmd.reject_nomatch) begin
				reject_q <= V_NOMATCH;
			end
			if (cmd.take_hit) begin
				count_q  <= count_m1;
				push_k_q <= rd_entry.push_len;
			end
			if (cmd.push_skip) begin
				push_k_q <= PLEN_W'(push_k_q - 1'b1);
			end
			if (cmd.push_write) begin
				push_k_q <= PLEN_W'(push_k_q - 1'b1);
				count_q  <= CNT_W'(count_q + 1'b1);
				if (count_q == '0) begin
					bottom_q <= push_sym;
				end
			end
			if (cmd.reject_over) begin
				reject_q <= V_OVER;
			end
			if (cmd.finish_symbol) begin
				cur_state_q <= hit_to_q;
			end
			if (cfg_fire) begin
				init_q <= cfg_data;
				if (!started_q) begin
					cur_state_q <= cfg_data;
				end
			end
			// end of string: report, then restart with the bottom symbol only
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= CNT_W'(1);
				bottom_q    <= SYM_BOTTOM;
				cur_state_q <= init_q;
				reject_q    <= V_ACCEPT;
				started_q   <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign verdict_code = verdict_q;

endmodule

// ----- sv/pushdown_automaton_recognizer_top.sv -----
// Top level of the table-driven pushdown automaton recognizer.
// Input channel (in_valid / in_stall): one beat is a load, clear, symbol or
//   end-of-string item, taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one verdict beat per end-of-string
//   item; accepted and verdict_code come from an output register.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the initial state;
//   cfg_ready is always high. Write it only while the block is idle.
// A symbol item scans the table from slot zero, one slot a cycle through the
//   table RAM, up to all 64 slots, until an entry fires; it then pushes that
//   entry's string, one character a cycle, '~' (skipped) included, up to 4.
//   A symbol that matches nothing scans all 64 slots; one that comes after a
//   rejection, or finds the stack empty, scans nothing.
// The verdict is registered from the S_END state once the output is free.
// A stalled verdict holds in the output register; load, clear and symbol
//   items still go through, and the next end item waits until it drains.
// Reset: every table entry invalid, stack holds the bottom symbol only,
//   state and initial state zero, no verdict pending.
`timescale 1ns / 1ps

module pushdown_automaton_recognizer_top import pda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [ENTRY_W-1:0] entry_index,
	input  logic [STATE_W-1:0] from_state,
	input  logic [STATE_W-1:0] to_state,
	input  logic [SYM_W-1:0]   symbol,
	input  logic [SYM_W-1:0]   stack_top_match,
	input  logic [PUSH_W-1:0]  push_symbols,
	input  logic [PLEN_W-1:0]  push_length,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [STATE_W-1:0] cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               accepted,
	output logic [CODE_W-1:0]  verdict_code
);

	cmd_t    cmd;
	status_t status;

	pda_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.in_stall(in_stall),
		.cmd     (cmd),
		.status  (status)
	);

	pda_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.entry_index    (entry_index),
		.from_state     (from_state),
		.to_state       (to_state),
		.symbol         (symbol),
		.stack_top_match(stack_top_match),
		.push_symbols   (push_symbols),
		.push_length    (push_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.accepted       (accepted),
		.verdict_code   (verdict_code)
	);

endmodule
